// ===== rtl/rdc_pkg.sv =====
// Shared constants, codes and types for the RGB dithered crossfade unit.
// No dependencies; imported by the top level, rdc_weight and the testbench.
package rdc_pkg;

    localparam int TABLE_INDEX_BITS = 12;
    localparam int TABLE_DEPTH      = 1 << TABLE_INDEX_BITS;
    localparam int TABLE_DATA_BITS  = 12;

    localparam logic [8:0] WEIGHT_FULL  = 9'd256;
    localparam logic [8:0] WEIGHT_RESET = 9'd128;

    typedef enum logic [1:0] {
        CMD_BLEND       = 2'd0,
        CMD_LOAD_RANDOM = 2'd1,
        CMD_LOAD_OFFSET = 2'd2,
        CMD_UNUSED      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_MIX_WEIGHT   = 2'd0,
        CFG_RANDOM_MODE  = 2'd1,
        CFG_RANDOM_SCALE = 2'd2,
        CFG_NONE         = 2'd3
    } cfg_index_t;

    // Register enables for the weight pipeline
    typedef struct packed {
        logic en_product;
        logic en_weight;
    } wt_ctrl_t;

endpackage

// ===== rtl/rgb_dithered_crossfade_unit.sv =====
// Top level of the RGB dithered crossfade unit: stream channels, config, pipeline control.
// Depends on rdc_pkg, rdc_ram and rdc_weight.
//
// Usage:
//   s_ channel: one transaction per command. s_tuser carries the command (blend, load
//   random table entry, load row offset entry); s_tdata carries the operands.
//   m_ channel: one transaction with the blended RGB pixel per blend command; load
//   commands and the unused command code produce nothing.
//   cfg_ channel: writes mix weight, random mode and random scale; always ready, to be
//   used only while no blend is in flight.
//   Pipeline: row offset read, random table read, scale multiply, weight clamp,
//   channel multiply, each registered before the result shows on m_tvalid; each memory
//   is read once per blend item on its own port.
//   Throughput: one transaction per cycle. When m_tready is low the stages fill up
//   one by one; s_tready drops only once every stage holds an item.
//   Reset: synchronous, active low. Config returns to weight 128, plain mode, scale 0;
//   all stages empty. Table contents are kept and are undefined until loaded.
module rgb_dithered_crossfade_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata from bit 0 up: column[15:0], row[15:0], table_index[11:0],
    // random_entry[11:0], offset_entry[11:0], a_red, a_green, a_blue,
    // b_red, b_green, b_blue (8 each), 4 zero pad bits
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic [1:0]   s_tuser,    // cmd[1:0]
    // m_tdata from bit 0 up: out_red, out_green, out_blue
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_data
);
    import rdc_pkg::*;

    localparam int TIB = TABLE_INDEX_BITS;

    typedef struct packed {
        logic [7:0] a_red;
        logic [7:0] a_green;
        logic [7:0] a_blue;
        logic [7:0] b_red;
        logic [7:0] b_green;
        logic [7:0] b_blue;
    } pix_t;

    function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] b,
                                              input logic [8:0] w);
        logic [16:0] s;
        s = 17'(a * w) + 17'(b * (WEIGHT_FULL - w));
        return s[15:8];
    endfunction

    // input unpacking
    cmd_t               s_cmd;
    logic [15:0]        s_column;
    logic [15:0]        s_row;
    logic [15:0]        s_tidx;
    logic [11:0]        s_random_entry;
    logic [11:0]        s_offset_entry;
    pix_t               s_pix;

    assign s_cmd          = cmd_t'(s_tuser);
    assign s_column       = s_tdata[15:0];
    assign s_row          = s_tdata[31:16];
    assign s_tidx         = 16'(s_tdata[43:32]);
    assign s_random_entry = s_tdata[55:44];
    assign s_offset_entry = s_tdata[67:56];
    assign s_pix.a_red    = s_tdata[75:68];
    assign s_pix.a_green  = s_tdata[83:76];
    assign s_pix.a_blue   = s_tdata[91:84];
    assign s_pix.b_red    = s_tdata[99:92];
    assign s_pix.b_green  = s_tdata[107:100];
    assign s_pix.b_blue   = s_tdata[115:108];

    // configuration
    logic [8:0]  mix_weight_reg;
    logic        random_mode_reg;
    logic [10:0] random_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_weight_reg   <= WEIGHT_RESET;
            random_mode_reg  <= 1'b0;
            random_scale_reg <= 11'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIX_WEIGHT:   mix_weight_reg   <= cfg_data[8:0];
                CFG_RANDOM_MODE:  random_mode_reg  <= cfg_data[0];
                CFG_RANDOM_SCALE: random_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdyo;
    logic accept, adv1, adv2, adv3, adv4;

    assign rdyo     = !vo_reg || m_tready;
    assign rdy4     = !v4_reg || rdyo;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign accept = s_tvalid && s_tready;
    assign adv1   = v1_reg && rdy2;
    assign adv2   = v2_reg && rdy3;
    assign adv3   = v3_reg && rdy4;
    assign adv4   = v4_reg && rdyo;

    // stage registers
    cmd_t        s1_cmd_reg;
    logic [15:0] s1_col_reg;
    logic [15:0] s1_tidx_reg;
    logic [11:0] s1_rnd_reg;
    pix_t        s1_pix_reg, s2_pix_reg, s3_pix_reg, s4_pix_reg;
    logic [7:0]  out_red_reg, out_green_reg, out_blue_reg;
    logic        v2_next;
    logic [8:0]  weight;

    assign v2_next = adv1 && (s1_cmd_reg == CMD_BLEND);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= accept;
            if (rdy2) v2_reg <= v2_next;
            if (rdy3) v3_reg <= adv2;
            if (rdy4) v4_reg <= adv3;
            if (rdyo) vo_reg <= adv4;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg  <= s_cmd;
            s1_col_reg  <= s_column;
            s1_tidx_reg <= s_tidx;
            s1_rnd_reg  <= s_random_entry;
            s1_pix_reg  <= s_pix;
        end
        if (adv1) s2_pix_reg <= s1_pix_reg;
        if (adv2) s3_pix_reg <= s2_pix_reg;
        if (adv3) s4_pix_reg <= s3_pix_reg;
        if (adv4) begin
            out_red_reg   <= blend_chan(s4_pix_reg.a_red,   s4_pix_reg.b_red,   weight);
            out_green_reg <= blend_chan(s4_pix_reg.a_green, s4_pix_reg.b_green, weight);
            out_blue_reg  <= blend_chan(s4_pix_reg.a_blue,  s4_pix_reg.b_blue,  weight);
        end
    end

    // row offset table: accessed as the transaction is accepted
    logic [TABLE_DATA_BITS-1:0] row_off;

    rdc_ram #(.AW(TIB), .DW(TABLE_DATA_BITS)) u_row_ram (
        .aclk  (aclk),
        .we    (accept && (s_cmd == CMD_LOAD_OFFSET)),
        .waddr (s_tidx[TIB-1:0]),
        .wdata (s_offset_entry),
        .re    (accept && (s_cmd == CMD_BLEND)),
        .raddr (s_row[TIB-1:0]),
        .rdata (row_off)
    );

    // random table: accessed as the item leaves stage 1
    logic [16:0]                rnd_sum;
    logic [TABLE_DATA_BITS-1:0] rnd_raw;

    assign rnd_sum = {1'b0, s1_col_reg} + 17'(row_off);

    rdc_ram #(.AW(TIB), .DW(TABLE_DATA_BITS)) u_rnd_ram (
        .aclk  (aclk),
        .we    (adv1 && (s1_cmd_reg == CMD_LOAD_RANDOM)),
        .waddr (s1_tidx_reg[TIB-1:0]),
        .wdata (s1_rnd_reg),
        .re    (v2_next),
        .raddr (rnd_sum[TIB-1:0]),
        .rdata (rnd_raw)
    );

    wt_ctrl_t   wt_ctrl;

    assign wt_ctrl.en_product = adv2;
    assign wt_ctrl.en_weight  = adv3;

    rdc_weight u_weight (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (wt_ctrl),
        .rnd_value    ($signed(rnd_raw)),
        .random_scale (random_scale_reg),
        .mix_weight   (mix_weight_reg),
        .random_mode  (random_mode_reg),
        .weight       (weight)
    );

    assign m_tvalid = vo_reg;
    assign m_tdata  = {out_blue_reg, out_green_reg, out_red_reg};

`ifndef SYNTHESIS
    a_hold_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !adv1 |=> v1_reg && $stable(s1_col_reg))
        else $error("stage 1 transaction lost or changed while stalled");

    a_loads_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        adv1 && (s1_cmd_reg != CMD_BLEND) |=> !v2_reg)
        else $error("non-blend transaction passed the table stage");

    a_out_from_stage4: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(v4_reg))
        else $error("result appeared without a stage 4 item");
`endif

endmodule

// ===== rtl/rdc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module rdc_ram #(
    parameter int AW = 12,
    parameter int DW = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rdc_weight.sv =====
// Weight pipeline: scale times random value, truncating divide by 4096, add in random mode, clamp.
// Depends on rdc_pkg.
module rdc_weight (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rdc_pkg::wt_ctrl_t    ctrl,
    input  logic signed [11:0]   rnd_value,
    input  logic [10:0]          random_scale,
    input  logic [8:0]           mix_weight,
    input  logic                 random_mode,
    output logic [8:0]           weight
);
    import rdc_pkg::*;

    logic signed [23:0] prod_reg;
    logic signed [11:0] delta;
    logic               round_up;
    logic signed [13:0] wsum;
    logic [8:0]         w_next;
    logic [8:0]         w_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en_product) begin
            prod_reg <= $signed({1'b0, random_scale}) * rnd_value;
        end
    end

    // shift rounds toward minus infinity; bump negatives with a remainder
    assign round_up = prod_reg[23] && (prod_reg[11:0] != 12'd0);
    assign delta    = prod_reg[23:12] + {11'd0, round_up};

    always_comb begin
        if (random_mode) begin
            wsum = $signed({5'd0, mix_weight}) + 14'(delta);
        end else begin
            wsum = $signed({5'd0, mix_weight});
        end
        if (wsum < 14'sd0) begin
            w_next = 9'd0;
        end else if (wsum > $signed({5'd0, WEIGHT_FULL})) begin
            w_next = WEIGHT_FULL;
        end else begin
            w_next = wsum[8:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en_weight) begin
            w_reg <= w_next;
        end
    end

    assign weight = w_reg;

`ifndef SYNTHESIS
    a_weight_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.en_weight |=> (w_reg <= WEIGHT_FULL))
        else $error("blend weight above full scale");

    a_plain_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.en_weight && !random_mode && (mix_weight <= WEIGHT_FULL)
        |=> (w_reg == $past(mix_weight)))
        else $error("plain mode weight differs from mix weight");
`endif

endmodule

// ===== tb/blend_scoreboard_pkg.sv =====
// Transaction layout and scoreboard for the RGB dithered crossfade unit testbench.
// The scoreboard mirrors the config registers and both lookup tables and predicts each pixel.
// Depends on rdc_pkg for command and register codes, table size and reset weight.
package blend_scoreboard_pkg;
    import rdc_pkg::*;

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  b_blue;
        logic [7:0]  b_green;
        logic [7:0]  b_red;
        logic [7:0]  a_blue;
        logic [7:0]  a_green;
        logic [7:0]  a_red;
        logic [11:0] offset_entry;
        logic [11:0] random_entry;
        logic [11:0] table_index;
        logic [15:0] row;
        logic [15:0] column;
    } crossfade_item_t;

    class blend_scoreboard;
        logic [8:0]                 mix_weight;
        logic                       random_mode;
        logic [10:0]                random_scale;
        logic [TABLE_DATA_BITS-1:0] random_values [TABLE_DEPTH];
        logic [TABLE_DATA_BITS-1:0] row_offsets [TABLE_DEPTH];
        logic [23:0]                pending_pixels [$];
        int                         errors;
        int                         blends;
        int                         loads;
        int                         unused_cmds;
        int                         checked;

        function new();
            mix_weight   = WEIGHT_RESET;
            random_mode  = 1'b0;
            random_scale = '0;
            foreach (random_values[i]) begin
                random_values[i] = '0;
                row_offsets[i]   = '0;
            end
            errors      = 0;
            blends      = 0;
            loads       = 0;
            unused_cmds = 0;
            checked     = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [10:0] value);
            case (idx)
                CFG_MIX_WEIGHT:   mix_weight   = value[8:0];
                CFG_RANDOM_MODE:  random_mode  = value[0];
                CFG_RANDOM_SCALE: random_scale = value;
                default: ;
            endcase
        endfunction

        function logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b, int w);
            int sum;
            sum = int'(a) * w + int'(b) * (256 - w);
            return sum[15:8];
        endfunction

        function void note_command(cmd_t cmd, crossfade_item_t it);
            int                          w;
            int                          entry;
            logic [TABLE_INDEX_BITS-1:0] slot;
            case (cmd)
                CMD_LOAD_RANDOM: begin
                    random_values[it.table_index[TABLE_INDEX_BITS-1:0]] = it.random_entry;
                    loads++;
                end
                CMD_LOAD_OFFSET: begin
                    row_offsets[it.table_index[TABLE_INDEX_BITS-1:0]] = it.offset_entry;
                    loads++;
                end
                CMD_BLEND: begin
                    w = int'(mix_weight);
                    if (random_mode) begin
                        slot = it.column[TABLE_INDEX_BITS-1:0]
                             + row_offsets[it.row[TABLE_INDEX_BITS-1:0]];
                        entry = int'($signed(random_values[slot]));
                        w += (int'(random_scale) * entry) / 4096;
                    end
                    if (w < 0)
                        w = 0;
                    else if (w > int'(WEIGHT_FULL))
                        w = int'(WEIGHT_FULL);
                    pending_pixels.push_back({mix_channel(it.a_blue, it.b_blue, w),
                                              mix_channel(it.a_green, it.b_green, w),
                                              mix_channel(it.a_red, it.b_red, w)});
                    blends++;
                end
                default: unused_cmds++;
            endcase
        endfunction

        function void check_pixel(logic [23:0] got, longint stamp);
            logic [23:0] want;
            string       names [3] = '{"red", "green", "blue"};
            checked++;
            if (pending_pixels.size() == 0) begin
                $display("[%0d ns] unexpected pixel: expected none, got 0x%06h", stamp, got);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            for (int c = 0; c < 3; c++) begin
                if (got[c*8 +: 8] !== want[c*8 +: 8]) begin
                    $display("[%0d ns] %s mismatch: expected %0d, got %0d", stamp, names[c],
                             want[c*8 +: 8], got[c*8 +: 8]);
                    errors++;
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for rgb_dithered_crossfade_unit: directed and random command streams
// under several register settings, random stalls on both channels and one long output hold.
// Depends on rdc_pkg, blend_scoreboard_pkg and the RTL of the unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rdc_pkg::*;
    import blend_scoreboard_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 96;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 185;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [10:0]  cfg_data;

    blend_scoreboard sb;
    bit              tx_gaps      = 1'b1;
    bit              rx_gaps      = 1'b1;
    bit              hold_request = 1'b0;
    int              settings     = 0;
    int              quiet_cycles = 0;
    int              rv_slots [$];
    int              ro_slots [$];

    rgb_dithered_crossfade_unit dut (.*);

    always #CLK_HALF aclk = ~aclk;

    function automatic crossfade_item_t random_fields();
        logic [127:0]    bits;
        crossfade_item_t it;
        bits   = {$urandom, $urandom, $urandom, $urandom};
        it     = bits[119:0];
        it.pad = '0;
        return it;
    endfunction

    // Half the time reuse the newest slot so loads are read back right away
    function automatic logic [11:0] pick_slot(input int slots [$]);
        if ($urandom_range(0, 1) == 0)
            return 12'(slots[slots.size() - 1]);
        return 12'(slots[$urandom_range(0, slots.size() - 1)]);
    endfunction

    task automatic send_item(input cmd_t cmd, input crossfade_item_t it);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, it);
    endtask

    task automatic load_random(input logic [11:0] slot, input logic [11:0] value);
        crossfade_item_t it;
        it              = random_fields();
        it.table_index  = slot;
        it.random_entry = value;
        rv_slots.push_back(int'(slot));
        send_item(CMD_LOAD_RANDOM, it);
    endtask

    task automatic load_offset(input logic [11:0] slot, input logic [11:0] value);
        crossfade_item_t it;
        it              = random_fields();
        it.table_index  = slot;
        it.offset_entry = value;
        ro_slots.push_back(int'(slot));
        send_item(CMD_LOAD_OFFSET, it);
    endtask

    task automatic send_blend(input logic [23:0] a, input logic [23:0] b,
                              input logic [15:0] col, input logic [15:0] row);
        crossfade_item_t it;
        it         = random_fields();
        it.column  = col;
        it.row     = row;
        {it.a_blue, it.a_green, it.a_red} = a;
        {it.b_blue, it.b_green, it.b_red} = b;
        send_item(CMD_BLEND, it);
    endtask

    // Loads leave nothing to wait on, so settle past the pipeline depth as well
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    task automatic apply_config(input logic [10:0] weight, input logic [10:0] mode,
                                input logic [10:0] scale, input bit poke_unused);
        wait_drained();
        if (poke_unused)
            cfg_write(CFG_NONE, 11'h7FF);
        cfg_write(CFG_MIX_WEIGHT, weight);
        cfg_write(CFG_RANDOM_MODE, mode);
        cfg_write(CFG_RANDOM_SCALE, scale);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(input int count);
        int          roll;
        logic [11:0] row_slot;
        logic [11:0] val_slot;
        logic [15:0] col;
        logic [15:0] row;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                load_random(12'($urandom), 12'($urandom));
            end else if (roll < 27) begin
                load_offset(12'($urandom), 12'($urandom));
            end else if (roll < 31) begin
                send_item(CMD_UNUSED, random_fields());
            end else begin
                col = 16'($urandom);
                row = 16'($urandom);
                // random mode may only read loaded entries
                if (sb.random_mode) begin
                    row_slot   = pick_slot(ro_slots);
                    val_slot   = pick_slot(rv_slots);
                    row[11:0]  = row_slot;
                    col[11:0]  = val_slot - sb.row_offsets[row_slot];
                end
                send_blend(24'($urandom), 24'($urandom), col, row);
            end
        end
    endtask

    initial begin : stimulus
        sb = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_BLEND;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_NONE;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: table extremes, pixel extremes, unused command
        load_random(12'h000, 12'h800);
        load_random(12'hFFF, 12'h7FF);
        load_random(12'h001, 12'h000);
        load_offset(12'h000, 12'h000);
        load_offset(12'hFFF, 12'hFFF);
        load_offset(12'h005, 12'h001);
        send_blend(24'hFFFFFF, 24'h000000, 16'h0000, 16'h0000);
        send_blend(24'h000000, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        send_blend(24'hFFFFFF, 24'hFFFFFF, 16'h8000, 16'h0001);
        send_blend(24'h000000, 24'h000000, 16'h1234, 16'hABCD);
        send_blend(24'($urandom), 24'($urandom), 16'hFFFF, 16'h0000);
        send_item(CMD_UNUSED, random_fields());

        // directed random dissolve: index wrap, clamp low, clamp high
        apply_config(11'd256, 11'd1, 11'd2047, 1'b0);
        send_blend(24'hFF80FF, 24'h00FF01, 16'h0001, 16'h0FFF);
        send_blend(24'hFF80FF, 24'h00FF01, 16'h0FFE, 16'h0005);
        send_blend(24'h7F01FE, 24'h80FE01, 16'hF001, 16'hF000);

        apply_config(11'd0, 11'd0, 11'd0, 1'b0);
        run_phase(PHASE_ITEMS);
        apply_config(11'd256, 11'd0, 11'd1024, 1'b0);
        run_phase(PHASE_ITEMS);
        apply_config(11'h1FF, 11'd0, 11'd2047, 1'b0);
        run_phase(PHASE_ITEMS);
        apply_config(11'd128, 11'd1, 11'd1024, 1'b1);
        run_phase(PHASE_ITEMS);
        apply_config(11'd0, 11'd1, 11'd2047, 1'b0);
        run_phase(PHASE_ITEMS);
        apply_config(11'd256, 11'd1, 11'd1024, 1'b0);
        run_phase(PHASE_ITEMS);
        apply_config(11'($urandom_range(0, 256)), 11'd1, 11'($urandom_range(0, 1024)), 1'b0);
        run_phase(PHASE_ITEMS);

        // back-pressure: output held while the input keeps offering
        apply_config(11'($urandom), 11'($urandom), 11'($urandom), 1'b0);
        tx_gaps      = 1'b0;
        hold_request = 1'b1;
        run_phase(PHASE_ITEMS);
        tx_gaps = 1'b1;

        // full rate on both sides
        apply_config(11'($urandom_range(0, 256)), 11'd1, 11'($urandom_range(0, 1024)), 1'b0);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_phase(PHASE_ITEMS);
        wait_drained();

        $display("Covered %0d blends, %0d table loads, %0d unused commands over %0d settings,",
                 sb.blends, sb.loads, sb.unused_cmds, settings);
        $display("random stalls and a %0d-cycle output hold; %0d pixels checked, %0d mismatches.",
                 HOLD_CYCLES, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : result_sink
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, $time);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0d ns] watchdog: no transaction for %0d cycles, %0d pixels outstanding",
                     $time, quiet_cycles, sb.pending_pixels.size());
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
